### rtl/core/lens_distortion_point_unit_defines.svh
// ----------------------------------------------------------------------------
// Lens distortion point unit: assertion macros
// Shared concurrent assertion forms for the checker of the distortion unit.
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_POINT_UNIT_DEFINES_SVH
`define LENS_DISTORTION_POINT_UNIT_DEFINES_SVH

// Assertion that is switched off while reset is asserted (active low reset)
`define LDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that is also checked through reset
`define LDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/ldp_pkg.sv
// ----------------------------------------------------------------------------
// Lens distortion point package
// Widths, register map, coefficient bundle and pipeline depth shared by the
// distortion unit, its datapath and its checker.
// ----------------------------------------------------------------------------
package ldp_pkg;

    // Field widths (Q3.20 coordinates, Q7.24 coefficients)
    localparam int COORD_W = 24;
    localparam int COEF_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register stages from input register to output register
    localparam int NUM_STAGES = 12;

    // Output clip limits
    localparam logic signed [COORD_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] OUT_MIN = 24'sh800000;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_K1,
        REG_K2,
        REG_K3,
        REG_P1,
        REG_P2
    } t_reg_idx;

    // Coefficient set handed to the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
        logic signed [COEF_W-1:0] p1;
        logic signed [COEF_W-1:0] p2;
    } t_coef;

endpackage

### rtl/core/lens_distortion_point_unit.sv
// ----------------------------------------------------------------------------
// Lens distortion point unit
// Brown-Conrady radial and tangential distortion of normalized points.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (i_s_*): one item per point, coord_u and coord_v in Q3.20.
//   Output stream (o_m_*): one item per input item, in order: dist_u and
//   dist_v in Q3.20, plus a flag in tuser when either one was clipped.
//   APB port: five Q7.24 coefficients k1, k2, k3, p1, p2 at byte addresses
//   0x00, 0x04, 0x08, 0x0C, 0x10; write them only while no item is in flight.
// Timing:
//   Latency from input acceptance to o_m_tvalid is set by the
//   chain of split multipliers r2 -> r2^2 -> r2^3 -> k3 term -> u * radial.
//   Throughput is one item per cycle while the output is not stalled.
// Reset and stall:
//   Reset clears all coefficients to zero and empties the pipeline.
//   Each stage holds its item while the next one is full and stalled, so a
//   stalled receiver fills the empty stages first; o_s_tready drops only
//   when all 12 stages hold items and i_m_tready is low.
// ----------------------------------------------------------------------------
module lens_distortion_point_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [47:0]                   i_s_tdata,   // [23:0] coord_u, [47:24] coord_v
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [47:0]                   o_m_tdata,   // [23:0] dist_u, [47:24] dist_v
    output logic [0:0]                    o_m_tuser,   // [0] saturated
    // configuration port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ldp_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [ldp_pkg::DATA_W-1:0]    i_pwdata,
    output logic [ldp_pkg::DATA_W-1:0]    o_prdata,
    output logic                          o_pready
);
    import ldp_pkg::*;

    t_coef                     r_coef;
    logic [NUM_STAGES-1:0]     r_vld;
    logic [NUM_STAGES:0]       w_rdy;
    logic signed [COORD_W-1:0] w_dist_u, w_dist_v;
    logic                      w_sat;

    // Coefficient writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[4:2])
                REG_K1:  r_coef.k1 <= i_pwdata;
                REG_K2:  r_coef.k2 <= i_pwdata;
                REG_K3:  r_coef.k3 <= i_pwdata;
                REG_P1:  r_coef.p1 <= i_pwdata;
                REG_P2:  r_coef.p2 <= i_pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (i_paddr[4:2])
            REG_K1:  o_prdata = r_coef.k1;
            REG_K2:  o_prdata = r_coef.k2;
            REG_K3:  o_prdata = r_coef.k3;
            REG_P1:  o_prdata = r_coef.p1;
            REG_P2:  o_prdata = r_coef.p2;
            default: o_prdata = '0;
        endcase
    end

    assign o_pready = 1'b1;

    // Per-stage ready: a stage loads when empty or when the next stage loads
    assign w_rdy[NUM_STAGES] = i_m_tready;

    genvar g;
    generate
        for (g = 0; g < NUM_STAGES; g++) begin : g_rdy
            assign w_rdy[g] = ~r_vld[g] | w_rdy[g+1];
        end
    endgenerate

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    ldp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_en        (w_rdy[NUM_STAGES-1:0]),
        .i_coef      (r_coef),
        .i_coord_u   (i_s_tdata[23:0]),
        .i_coord_v   (i_s_tdata[47:24]),
        .o_dist_u    (w_dist_u),
        .o_dist_v    (w_dist_v),
        .o_saturated (w_sat)
    );

    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_tdata  = {w_dist_v, w_dist_u};
    assign o_m_tuser  = w_sat;

endmodule

### rtl/core/ldp_datapath.sv
// ----------------------------------------------------------------------------
// Lens distortion datapath
// Twelve register stages computing the Brown-Conrady radial and tangential
// distortion of one point; wide products are split into partial products.
// ----------------------------------------------------------------------------
module ldp_datapath (
    input  logic                                i_clk,
    input  logic [ldp_pkg::NUM_STAGES-1:0]      i_en,
    input  ldp_pkg::t_coef                      i_coef,
    input  logic signed [ldp_pkg::COORD_W-1:0]  i_coord_u,
    input  logic signed [ldp_pkg::COORD_W-1:0]  i_coord_v,
    output logic signed [ldp_pkg::COORD_W-1:0]  o_dist_u,
    output logic signed [ldp_pkg::COORD_W-1:0]  o_dist_v,
    output logic                                o_saturated
);
    import ldp_pkg::*;

    // Round a tangential product, split as hi * 2^25 + lo, to Q.20 (shift 44)
    function automatic logic signed [39:0] tan_round(input logic signed [56:0] hi,
                                                     input logic signed [57:0] lo);
        logic signed [83:0] h;
        logic signed [83:0] l;
        logic signed [83:0] s;
        h = hi;
        l = lo;
        s = (h <<< 25) + l + (84'sd1 <<< 43);
        return s[83:44];
    endfunction

    // Clip a Q.20 sum to the output range
    function automatic logic [COORD_W:0] clip(input logic signed [57:0] s);
        logic [COORD_W:0] res;
        if (s > OUT_MAX) begin
            res = {1'b1, OUT_MAX};
        end else if (s < OUT_MIN) begin
            res = {1'b1, OUT_MIN};
        end else begin
            res = {1'b0, s[COORD_W-1:0]};
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: u*u, v*v, u*v (exact Q.40)
    // ------------------------------------------------------------------
    logic signed [47:0]        r_uu_s1, r_vv_s1, r_uv_s1;
    logic signed [COORD_W-1:0] r_u_s1, r_v_s1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_uu_s1 <= i_coord_u * i_coord_u;
            r_vv_s1 <= i_coord_v * i_coord_v;
            r_uv_s1 <= i_coord_u * i_coord_v;
            r_u_s1  <= i_coord_u;
            r_v_s1  <= i_coord_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: r2, 3uu+vv, 3vv+uu, 2uv
    // ------------------------------------------------------------------
    logic [47:0]               n_r2_s2, r_r2_s2;
    logic [48:0]               n_tu_s2, r_tu_s2, n_tv_s2, r_tv_s2;
    logic signed [48:0]        n_uv2_s2, r_uv2_s2;
    logic signed [COORD_W-1:0] r_u_s2, r_v_s2;

    always_comb begin
        n_r2_s2  = {1'b0, r_uu_s1[46:0]} + {1'b0, r_vv_s1[46:0]};
        n_tu_s2  = {2'b0, r_uu_s1[46:0]} + {1'b0, r_uu_s1[46:0], 1'b0}
                 + {2'b0, r_vv_s1[46:0]};
        n_tv_s2  = {2'b0, r_vv_s1[46:0]} + {1'b0, r_vv_s1[46:0], 1'b0}
                 + {2'b0, r_uu_s1[46:0]};
        n_uv2_s2 = {r_uv_s1, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_r2_s2  <= n_r2_s2;
            r_tu_s2  <= n_tu_s2;
            r_tv_s2  <= n_tv_s2;
            r_uv2_s2 <= n_uv2_s2;
            r_u_s2   <= r_u_s1;
            r_v_s2   <= r_v_s1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: partial products of r2*r2, k1*r2 and the tangential terms
    // ------------------------------------------------------------------
    logic [23:0]               w_r2h_s3, w_r2l_s3;
    logic [47:0]               n_hh_s3, n_hl_s3, n_ll_s3;
    logic [47:0]               r_hh_s3, r_hl_s3, r_ll_s3;
    logic signed [56:0]        n_k1h_s3, n_k1l_s3, r_k1h_s3, r_k1l_s3;
    logic signed [56:0]        n_pah_s3, n_pbh_s3, n_pch_s3, n_pdh_s3;
    logic signed [57:0]        n_pal_s3, n_pbl_s3, n_pcl_s3, n_pdl_s3;
    logic signed [56:0]        r_pah_s3, r_pbh_s3, r_pch_s3, r_pdh_s3;
    logic signed [57:0]        r_pal_s3, r_pbl_s3, r_pcl_s3, r_pdl_s3;
    logic [47:0]               r_r2_s3;
    logic signed [COORD_W-1:0] r_u_s3, r_v_s3;

    always_comb begin
        w_r2h_s3 = r_r2_s2[47:24];
        w_r2l_s3 = r_r2_s2[23:0];
        n_hh_s3  = w_r2h_s3 * w_r2h_s3;
        n_hl_s3  = w_r2h_s3 * w_r2l_s3;
        n_ll_s3  = w_r2l_s3 * w_r2l_s3;
        n_k1h_s3 = $signed(i_coef.k1) * $signed({1'b0, w_r2h_s3});
        n_k1l_s3 = $signed(i_coef.k1) * $signed({1'b0, w_r2l_s3});
        // p1 * 2uv (du), split at bit 25
        n_pah_s3 = $signed(i_coef.p1) * $signed(r_uv2_s2[48:25]);
        n_pal_s3 = $signed(i_coef.p1) * $signed({1'b0, r_uv2_s2[24:0]});
        // p2 * (r2 + 2uu) (du)
        n_pbh_s3 = $signed(i_coef.p2) * $signed({1'b0, r_tu_s2[48:25]});
        n_pbl_s3 = $signed(i_coef.p2) * $signed({1'b0, r_tu_s2[24:0]});
        // p1 * (r2 + 2vv) (dv)
        n_pch_s3 = $signed(i_coef.p1) * $signed({1'b0, r_tv_s2[48:25]});
        n_pcl_s3 = $signed(i_coef.p1) * $signed({1'b0, r_tv_s2[24:0]});
        // p2 * 2uv (dv)
        n_pdh_s3 = $signed(i_coef.p2) * $signed(r_uv2_s2[48:25]);
        n_pdl_s3 = $signed(i_coef.p2) * $signed({1'b0, r_uv2_s2[24:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_hh_s3  <= n_hh_s3;
            r_hl_s3  <= n_hl_s3;
            r_ll_s3  <= n_ll_s3;
            r_k1h_s3 <= n_k1h_s3;
            r_k1l_s3 <= n_k1l_s3;
            r_pah_s3 <= n_pah_s3;
            r_pal_s3 <= n_pal_s3;
            r_pbh_s3 <= n_pbh_s3;
            r_pbl_s3 <= n_pbl_s3;
            r_pch_s3 <= n_pch_s3;
            r_pcl_s3 <= n_pcl_s3;
            r_pdh_s3 <= n_pdh_s3;
            r_pdl_s3 <= n_pdl_s3;
            r_r2_s3  <= r_r2_s2;
            r_u_s3   <= r_u_s2;
            r_v_s3   <= r_v_s2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: r4 = rnd(r2^2 >> 40), k1 term, four tangential terms
    // ------------------------------------------------------------------
    logic [95:0]               w_sq_s4;
    logic signed [81:0]        w_k1h_s4, w_k1l_s4, w_k1s_s4;
    logic [54:0]               n_r4_s4, r_r4_s4;
    logic signed [39:0]        n_t1_s4, r_t1_s4;
    logic signed [39:0]        n_ta_s4, n_tb_s4, n_tc_s4, n_td_s4;
    logic signed [39:0]        r_ta_s4, r_tb_s4, r_tc_s4, r_td_s4;
    logic [47:0]               r_r2_s4;
    logic signed [COORD_W-1:0] r_u_s4, r_v_s4;

    always_comb begin
        w_sq_s4  = {r_hh_s3, 48'b0} + {23'b0, r_hl_s3, 25'b0} + {48'b0, r_ll_s3}
                 + (96'd1 << 39);
        n_r4_s4  = w_sq_s4[94:40];
        w_k1h_s4 = r_k1h_s3;
        w_k1l_s4 = r_k1l_s3;
        w_k1s_s4 = (w_k1h_s4 <<< 24) + w_k1l_s4 + (82'sd1 <<< 39);
        n_t1_s4  = w_k1s_s4[79:40];
        n_ta_s4  = tan_round(r_pah_s3, r_pal_s3);
        n_tb_s4  = tan_round(r_pbh_s3, r_pbl_s3);
        n_tc_s4  = tan_round(r_pch_s3, r_pcl_s3);
        n_td_s4  = tan_round(r_pdh_s3, r_pdl_s3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_r4_s4 <= n_r4_s4;
            r_t1_s4 <= n_t1_s4;
            r_ta_s4 <= n_ta_s4;
            r_tb_s4 <= n_tb_s4;
            r_tc_s4 <= n_tc_s4;
            r_td_s4 <= n_td_s4;
            r_r2_s4 <= r_r2_s3;
            r_u_s4  <= r_u_s3;
            r_v_s4  <= r_v_s3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: partial products of r4*r2 and k2*r4, tangential sums
    // ------------------------------------------------------------------
    logic [26:0]               w_a1_s5;
    logic [27:0]               w_a0_s5;
    logic [23:0]               w_b1_s5, w_b0_s5;
    logic [51:0]               n_p11_s5, n_p10_s5, n_p01_s5, n_p00_s5;
    logic [51:0]               r_p11_s5, r_p10_s5, r_p01_s5, r_p00_s5;
    logic signed [60:0]        n_k2h_s5, n_k2l_s5, r_k2h_s5, r_k2l_s5;
    logic signed [40:0]        n_tanu_s5, n_tanv_s5, r_tanu_s5, r_tanv_s5;
    logic signed [39:0]        r_t1_s5;
    logic signed [COORD_W-1:0] r_u_s5, r_v_s5;

    always_comb begin
        w_a1_s5   = r_r4_s4[54:28];
        w_a0_s5   = r_r4_s4[27:0];
        w_b1_s5   = r_r2_s4[47:24];
        w_b0_s5   = r_r2_s4[23:0];
        n_p11_s5  = w_a1_s5 * w_b1_s5;
        n_p10_s5  = w_a1_s5 * w_b0_s5;
        n_p01_s5  = w_a0_s5 * w_b1_s5;
        n_p00_s5  = w_a0_s5 * w_b0_s5;
        n_k2h_s5  = $signed(i_coef.k2) * $signed({1'b0, w_a1_s5});
        n_k2l_s5  = $signed(i_coef.k2) * $signed({1'b0, w_a0_s5});
        n_tanu_s5 = r_ta_s4 + r_tb_s4;
        n_tanv_s5 = r_tc_s4 + r_td_s4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_p11_s5  <= n_p11_s5;
            r_p10_s5  <= n_p10_s5;
            r_p01_s5  <= n_p01_s5;
            r_p00_s5  <= n_p00_s5;
            r_k2h_s5  <= n_k2h_s5;
            r_k2l_s5  <= n_k2l_s5;
            r_tanu_s5 <= n_tanu_s5;
            r_tanv_s5 <= n_tanv_s5;
            r_t1_s5   <= r_t1_s4;
            r_u_s5    <= r_u_s4;
            r_v_s5    <= r_v_s4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: r6 = rnd(r4*r2 >> 40), k2 term
    // ------------------------------------------------------------------
    logic [103:0]              w_cu_s6;
    logic signed [89:0]        w_k2h_s6, w_k2l_s6, w_k2s_s6;
    logic [61:0]               n_r6_s6, r_r6_s6;
    logic signed [47:0]        n_t2_s6, r_t2_s6;
    logic signed [39:0]        r_t1_s6;
    logic signed [40:0]        r_tanu_s6, r_tanv_s6;
    logic signed [COORD_W-1:0] r_u_s6, r_v_s6;

    always_comb begin
        w_cu_s6  = {r_p11_s5, 52'b0} + {24'b0, r_p10_s5, 28'b0}
                 + {28'b0, r_p01_s5, 24'b0} + {52'b0, r_p00_s5} + (104'd1 << 39);
        n_r6_s6  = w_cu_s6[101:40];
        w_k2h_s6 = r_k2h_s5;
        w_k2l_s6 = r_k2l_s5;
        w_k2s_s6 = (w_k2h_s6 <<< 28) + w_k2l_s6 + (90'sd1 <<< 39);
        n_t2_s6  = w_k2s_s6[87:40];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_r6_s6   <= n_r6_s6;
            r_t2_s6   <= n_t2_s6;
            r_t1_s6   <= r_t1_s5;
            r_tanu_s6 <= r_tanu_s5;
            r_tanv_s6 <= r_tanv_s5;
            r_u_s6    <= r_u_s5;
            r_v_s6    <= r_v_s5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: partial products of k3*r6, k1 + k2 terms
    // ------------------------------------------------------------------
    logic signed [63:0]        n_k3h_s7, n_k3l_s7, r_k3h_s7, r_k3l_s7;
    logic signed [48:0]        n_rad12_s7, r_rad12_s7;
    logic signed [40:0]        r_tanu_s7, r_tanv_s7;
    logic signed [COORD_W-1:0] r_u_s7, r_v_s7;

    always_comb begin
        n_k3h_s7   = $signed(i_coef.k3) * $signed({1'b0, r_r6_s6[61:31]});
        n_k3l_s7   = $signed(i_coef.k3) * $signed({1'b0, r_r6_s6[30:0]});
        n_rad12_s7 = r_t1_s6 + r_t2_s6;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_k3h_s7   <= n_k3h_s7;
            r_k3l_s7   <= n_k3l_s7;
            r_rad12_s7 <= n_rad12_s7;
            r_tanu_s7  <= r_tanu_s6;
            r_tanv_s7  <= r_tanv_s6;
            r_u_s7     <= r_u_s6;
            r_v_s7     <= r_v_s6;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: k3 term
    // ------------------------------------------------------------------
    logic signed [95:0]        w_k3h_s8, w_k3l_s8, w_k3s_s8;
    logic signed [55:0]        n_t3_s8, r_t3_s8;
    logic signed [48:0]        r_rad12_s8;
    logic signed [40:0]        r_tanu_s8, r_tanv_s8;
    logic signed [COORD_W-1:0] r_u_s8, r_v_s8;

    always_comb begin
        w_k3h_s8 = r_k3h_s7;
        w_k3l_s8 = r_k3l_s7;
        w_k3s_s8 = (w_k3h_s8 <<< 31) + w_k3l_s8 + (96'sd1 <<< 39);
        n_t3_s8  = w_k3s_s8[95:40];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_t3_s8    <= n_t3_s8;
            r_rad12_s8 <= r_rad12_s7;
            r_tanu_s8  <= r_tanu_s7;
            r_tanv_s8  <= r_tanv_s7;
            r_u_s8     <= r_u_s7;
            r_v_s8     <= r_v_s7;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: radial factor (Q.24)
    // ------------------------------------------------------------------
    logic signed [55:0]        n_rad_s9, r_rad_s9;
    logic signed [40:0]        r_tanu_s9, r_tanv_s9;
    logic signed [COORD_W-1:0] r_u_s9, r_v_s9;

    always_comb begin
        n_rad_s9 = r_rad12_s8 + r_t3_s8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_rad_s9  <= n_rad_s9;
            r_tanu_s9 <= r_tanu_s8;
            r_tanv_s9 <= r_tanv_s8;
            r_u_s9    <= r_u_s8;
            r_v_s9    <= r_v_s8;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: partial products of u*radial and v*radial
    // ------------------------------------------------------------------
    logic signed [52:0]        n_urh_s10, n_url_s10, n_vrh_s10, n_vrl_s10;
    logic signed [52:0]        r_urh_s10, r_url_s10, r_vrh_s10, r_vrl_s10;
    logic signed [40:0]        r_tanu_s10, r_tanv_s10;
    logic signed [COORD_W-1:0] r_u_s10, r_v_s10;

    always_comb begin
        n_urh_s10 = r_u_s9 * $signed(r_rad_s9[55:28]);
        n_url_s10 = r_u_s9 * $signed({1'b0, r_rad_s9[27:0]});
        n_vrh_s10 = r_v_s9 * $signed(r_rad_s9[55:28]);
        n_vrl_s10 = r_v_s9 * $signed({1'b0, r_rad_s9[27:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r_urh_s10  <= n_urh_s10;
            r_url_s10  <= n_url_s10;
            r_vrh_s10  <= n_vrh_s10;
            r_vrl_s10  <= n_vrl_s10;
            r_tanu_s10 <= r_tanu_s9;
            r_tanv_s10 <= r_tanv_s9;
            r_u_s10    <= r_u_s9;
            r_v_s10    <= r_v_s9;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: round u*radial and v*radial to Q.20
    // ------------------------------------------------------------------
    logic signed [79:0]        w_urh_s11, w_url_s11, w_urs_s11;
    logic signed [79:0]        w_vrh_s11, w_vrl_s11, w_vrs_s11;
    logic signed [55:0]        n_ur_s11, n_vr_s11, r_ur_s11, r_vr_s11;
    logic signed [40:0]        r_tanu_s11, r_tanv_s11;
    logic signed [COORD_W-1:0] r_u_s11, r_v_s11;

    always_comb begin
        w_urh_s11 = r_urh_s10;
        w_url_s11 = r_url_s10;
        w_vrh_s11 = r_vrh_s10;
        w_vrl_s11 = r_vrl_s10;
        w_urs_s11 = (w_urh_s11 <<< 28) + w_url_s11 + (80'sd1 <<< 23);
        w_vrs_s11 = (w_vrh_s11 <<< 28) + w_vrl_s11 + (80'sd1 <<< 23);
        n_ur_s11  = w_urs_s11[79:24];
        n_vr_s11  = w_vrs_s11[79:24];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[10]) begin
            r_ur_s11   <= n_ur_s11;
            r_vr_s11   <= n_vr_s11;
            r_tanu_s11 <= r_tanu_s10;
            r_tanv_s11 <= r_tanv_s10;
            r_u_s11    <= r_u_s10;
            r_v_s11    <= r_v_s10;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: final sums, clip, output register
    // ------------------------------------------------------------------
    logic signed [57:0]        w_su_s12, w_sv_s12;
    logic [COORD_W:0]          w_cu_s12, w_cv_s12;
    logic signed [COORD_W-1:0] n_du_s12, n_dv_s12, r_du_s12, r_dv_s12;
    logic                      n_sat_s12, r_sat_s12;

    always_comb begin
        w_su_s12  = r_u_s11 + r_ur_s11 + r_tanu_s11;
        w_sv_s12  = r_v_s11 + r_vr_s11 + r_tanv_s11;
        w_cu_s12  = clip(w_su_s12);
        w_cv_s12  = clip(w_sv_s12);
        n_du_s12  = w_cu_s12[COORD_W-1:0];
        n_dv_s12  = w_cv_s12[COORD_W-1:0];
        n_sat_s12 = w_cu_s12[COORD_W] | w_cv_s12[COORD_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[11]) begin
            r_du_s12  <= n_du_s12;
            r_dv_s12  <= n_dv_s12;
            r_sat_s12 <= n_sat_s12;
        end
    end

    assign o_dist_u    = r_du_s12;
    assign o_dist_v    = r_dv_s12;
    assign o_saturated = r_sat_s12;

endmodule

### rtl/core/ldp_checker.sv
// ----------------------------------------------------------------------------
// Lens distortion point checker
// Port-level assertions for the distortion unit, attached by bind.
// ----------------------------------------------------------------------------
`include "lens_distortion_point_unit_defines.svh"

module ldp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [47:0]                 o_m_tdata,
    input logic [0:0]                  o_m_tuser
);
    import ldp_pkg::*;

    // A stalled result item holds its payload
    `LDP_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "output item changed while stalled")

    // Input side stalls only when the pipe is full and the receiver stalls
    `LDP_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_s_tready |-> o_m_tvalid && !i_m_tready, "input stalled without output backpressure")

    // A saturated item carries a clip limit in at least one coordinate
    `LDP_ASSERT(a_sat_limit, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[23:0] == OUT_MAX || o_m_tdata[23:0] == OUT_MIN || o_m_tdata[47:24] == OUT_MAX || o_m_tdata[47:24] == OUT_MIN, "saturated flag without clipped value")

    // Reset empties the pipeline
    `LDP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid right after reset")

endmodule

bind lens_distortion_point_unit ldp_checker u_ldp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lens distortion point unit testbench
// Streams normalized points through the unit under a range of coefficient
// sets and compares every distorted point and clip flag against a bit-exact
// fixed-point model of the radial/tangential distortion. Covers identity
// behavior, k1, k2, p1 and p2 alone, saturation, ignored register writes,
// a long output hold-off and a large randomized run with bursty traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import ldp_pkg::*;

    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int MAX_MISMATCH_PRINTS = 40;

    // Ready pattern of the receiver in pattern mode, one bit per cycle
    localparam logic [15:0] RX_STALL_PATTERN = 16'b1011_0010_1110_0110;

    // Register slots past the end of the map
    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_PATTERN
    } t_rx_mode;

    // One distorted point as seen on the output stream
    typedef struct packed {
        logic [COORD_W-1:0] du;
        logic [COORD_W-1:0] dv;
        logic               sat;
    } t_dist_point;

    // DUT ports; the inputs are known from time zero
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [47:0]        i_s_tdata  = '0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [47:0]        o_m_tdata;
    logic [0:0]         o_m_tuser;
    logic               i_psel     = 1'b0;
    logic               i_penable  = 1'b0;
    logic               i_pwrite   = 1'b0;
    logic [ADDR_W-1:0]  i_paddr    = '0;
    logic [DATA_W-1:0]  i_pwdata   = '0;
    logic [DATA_W-1:0]  o_prdata;
    logic               o_pready;

    // Coefficients as the model sees them
    logic signed [COEF_W-1:0] coef_k1 = '0;
    logic signed [COEF_W-1:0] coef_k2 = '0;
    logic signed [COEF_W-1:0] coef_k3 = '0;
    logic signed [COEF_W-1:0] coef_p1 = '0;
    logic signed [COEF_W-1:0] coef_p2 = '0;

    t_dist_point distorted_q[$];

    // Sender and receiver controls
    int       tx_gap_max    = 0;
    int       tx_burst_left = 0;
    t_rx_mode rx_mode       = RX_ALWAYS;
    bit       rx_hold_req   = 1'b0;
    int       rx_hold_left  = 0;
    int       rx_cnt        = 0;

    // Statistics
    int fail_count      = 0;
    int mismatch_prints = 0;
    int points_sent     = 0;
    int results_seen    = 0;
    int sat_seen        = 0;
    int coef_sets       = 0;

    lens_distortion_point_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always #1 i_clk = ~i_clk;

    // round(a*b / 2^sh), half toward +inf, clamped to 64 bits
    function automatic logic signed [63:0] round_mul_shift(input logic signed [63:0] a,
                                                           input logic signed [63:0] b,
                                                           input int sh);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        logic signed [63:0]  lim_lo;
        logic signed [127:0] wide_hi;
        logic signed [127:0] wide_lo;
        wa      = a;
        wb      = b;
        lim_lo  = 64'sh8000_0000_0000_0000;
        wide_hi = 64'sh7FFF_FFFF_FFFF_FFFF;
        wide_lo = lim_lo;
        prod = wa * wb;
        prod = prod + (128'sd1 <<< (sh - 1));
        prod = prod >>> sh;
        if (prod > wide_hi)
            return wide_hi[63:0];
        if (prod < wide_lo)
            return lim_lo;
        return prod[63:0];
    endfunction

    // Brown-Conrady distortion of one Q3.20 point with the current coefficients
    function automatic t_dist_point predict_distortion(input logic [COORD_W-1:0] u_bits,
                                                       input logic [COORD_W-1:0] v_bits);
        logic signed [COORD_W-1:0] su;
        logic signed [COORD_W-1:0] sv;
        logic signed [63:0] u, v, uu, vv, uv, r2, r4, r6, radial, du, dv;
        logic signed [63:0] k1, k2, k3, p1, p2;
        t_dist_point res;
        su = u_bits;
        sv = v_bits;
        u  = su;
        v  = sv;
        k1 = coef_k1;
        k2 = coef_k2;
        k3 = coef_k3;
        p1 = coef_p1;
        p2 = coef_p2;
        uu = u * u;
        vv = v * v;
        uv = u * v;
        r2 = uu + vv;
        r4 = round_mul_shift(r2, r2, 40);
        r6 = round_mul_shift(r4, r2, 40);
        radial = round_mul_shift(k1, r2, 40) + round_mul_shift(k2, r4, 40)
               + round_mul_shift(k3, r6, 40);
        du = u + round_mul_shift(u, radial, 24) + round_mul_shift(p1, 2 * uv, 44)
               + round_mul_shift(p2, r2 + 2 * uu, 44);
        dv = v + round_mul_shift(v, radial, 24) + round_mul_shift(p1, r2 + 2 * vv, 44)
               + round_mul_shift(p2, 2 * uv, 44);
        res.sat = 1'b0;
        if (du > OUT_MAX) begin
            du = OUT_MAX;
            res.sat = 1'b1;
        end else if (du < OUT_MIN) begin
            du = OUT_MIN;
            res.sat = 1'b1;
        end
        if (dv > OUT_MAX) begin
            dv = OUT_MAX;
            res.sat = 1'b1;
        end else if (dv < OUT_MIN) begin
            dv = OUT_MIN;
            res.sat = 1'b1;
        end
        res.du = du[COORD_W-1:0];
        res.dv = dv[COORD_W-1:0];
        return res;
    endfunction

    // Receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        rx_cnt = rx_cnt + 1;
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_m_tready <= 1'b1;
                RX_RANDOM:  i_m_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE:  i_m_tready <= ($urandom_range(0, 3) == 0);
                default:    i_m_tready <= RX_STALL_PATTERN[rx_cnt[3:0]];
            endcase
        end
    end

    // Output checker: each accepted item against the oldest expectation
    always @(posedge i_clk) begin
        t_dist_point want;
        t_dist_point got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.du  = o_m_tdata[23:0];
            got.dv  = o_m_tdata[47:24];
            got.sat = o_m_tuser[0];
            results_seen = results_seen + 1;
            if (got.sat)
                sat_seen = sat_seen + 1;
            if (distorted_q.size() == 0) begin
                fail_count = fail_count + 1;
                if (mismatch_prints < MAX_MISMATCH_PRINTS)
                    $display("%0t: unexpected output item du=%h dv=%h sat=%b",
                             $time, got.du, got.dv, got.sat);
                mismatch_prints = mismatch_prints + 1;
            end else begin
                want = distorted_q.pop_front();
                if (want != got) begin
                    fail_count = fail_count + 1;
                    if (mismatch_prints < MAX_MISMATCH_PRINTS) begin
                        if (want.du != got.du)
                            $display("%0t: dist_u expected %h got %h",
                                     $time, want.du, got.du);
                        if (want.dv != got.dv)
                            $display("%0t: dist_v expected %h got %h",
                                     $time, want.dv, got.dv);
                        if (want.sat != got.sat)
                            $display("%0t: saturated expected %b got %b",
                                     $time, want.sat, got.sat);
                    end
                    mismatch_prints = mismatch_prints + 1;
                end
            end
        end
    end

    // Offer one point; with tx_gap_max set, the sender runs in bursts with random gaps
    task automatic send_point(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        int gap;
        if (tx_gap_max > 0 && tx_burst_left == 0) begin
            gap = $urandom_range(1, tx_gap_max);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            tx_burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {v, u};
        do @(posedge i_clk); while (!o_s_tready);
        distorted_q.push_back(predict_distortion(u, v));
        points_sent = points_sent + 1;
        if (tx_burst_left > 0)
            tx_burst_left = tx_burst_left - 1;
    endtask

    // Stop sending and wait until every expected item has come out
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        tx_burst_left = 0;
        do @(posedge i_clk); while (distorted_q.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, register takes the value
    task automatic write_coef(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        case (idx)
            REG_K1:  coef_k1 = value;
            REG_K2:  coef_k2 = value;
            REG_K3:  coef_k3 = value;
            REG_P1:  coef_p1 = value;
            REG_P2:  coef_p2 = value;
            default: ;
        endcase
    endtask

    task automatic load_coefs(input logic [31:0] k1, input logic [31:0] k2,
                              input logic [31:0] k3, input logic [31:0] p1,
                              input logic [31:0] p2);
        wait_drained();
        write_coef(REG_K1, k1);
        write_coef(REG_K2, k2);
        write_coef(REG_K3, k3);
        write_coef(REG_P1, p1);
        write_coef(REG_P2, p2);
        coef_sets = coef_sets + 1;
    endtask

    // Mostly small, realistic coordinates; some full range and extremes
    function automatic logic [COORD_W-1:0] rand_coord();
        int pick;
        int val;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                case ($urandom_range(0, 3))
                    0: val = 24'h7FFFFF;
                    1: val = 24'h800000;
                    2: val = 0;
                    default: val = 24'h100000;
                endcase
            end
            1, 2, 3: val = $urandom();
            default: val = int'($urandom_range(0, 24'h3FFFFF)) - 24'sh200000;
        endcase
        return val[COORD_W-1:0];
    endfunction

    // Coefficients: extremes, full range, and values near the usual scale
    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            4:       return 32'h0;
            default: return int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        endcase
    endfunction

    // Zero coefficients: output equals input, extremes of the fields
    task automatic test_identity();
        rx_mode    = RX_RANDOM;
        tx_gap_max = 3;
        send_point(24'h000000, 24'h000000);
        send_point(24'h7FFFFF, 24'h7FFFFF);
        send_point(24'h800000, 24'h800000);
        send_point(24'h7FFFFF, 24'h800000);
        send_point(24'h800000, 24'h7FFFFF);
        send_point(24'h000001, 24'hFFFFFF);
        send_point(24'h555555, 24'hAAAAAA);
        send_point(24'hAAAAAA, 24'h555555);
    endtask

    // Radial terms: k1 and k2 one at a time, then k1, k2 and k3 together
    task automatic test_radial();
        load_coefs(32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_point(24'h080000, 24'hF80000);
        load_coefs(32'h0, 32'hFF80_0000, 32'h0, 32'h0, 32'h0);
        send_point(24'h0C0000, 24'h040000);
        load_coefs(32'hFFC0_0000, 32'h0040_0000, 32'h0020_0000, 32'h0, 32'h0);
        send_point(24'h100000, 24'h100000);
        send_point(24'hF00000, 24'h0A0000);
    endtask

    // Tangential terms on their own
    task automatic test_tangential();
        load_coefs(32'h0, 32'h0, 32'h0, 32'h0040_0000, 32'h0);
        send_point(24'h080000, 24'h0C0000);
        load_coefs(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFA0_0000);
        send_point(24'hF40000, 24'h060000);
        send_point(24'h7FFFFF, 24'h800000);
    endtask

    // Clipping high and low, on each coordinate
    task automatic test_saturation();
        load_coefs(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
        send_point(24'h100000, 24'h100000);
        send_point(24'hF00000, 24'h000100);
        load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(24'h7FFFFF, 24'h800000);
        send_point(24'h000400, 24'h7FFFFF);
    endtask

    // Writes beyond the last register leave the coefficients alone
    task automatic test_ignored_address();
        load_coefs(32'h0080_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000);
        write_coef(REG_UNUSED_LO, 32'h7FFF_FFFF);
        write_coef(REG_UNUSED_HI, 32'h8000_0000);
        send_point(24'h0A0000, 24'hF60000);
        send_point(24'h7FFFFF, 24'h7FFFFF);
    endtask

    // Output held off for a long stretch while points keep coming
    task automatic test_backpressure();
        load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        rx_mode    = RX_ALWAYS;
        tx_gap_max = 0;
        rx_hold_req = 1'b1;
        repeat (48) send_point(rand_coord(), rand_coord());
        wait_drained();
        rx_mode = RX_PATTERN;
        repeat (24) send_point(rand_coord(), rand_coord());
    endtask

    // Random phases, each with its own coefficients and traffic shape
    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF);
                1: load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000);
                default: load_coefs(rand_coef(), rand_coef(), rand_coef(),
                                    rand_coef(), rand_coef());
            endcase
            rx_mode    = t_rx_mode'($urandom_range(0, 3));
            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            n = $urandom_range(85, 110);
            repeat (n) send_point(rand_coord(), rand_coord());
        end
    endtask

    // Run-time limit
    initial begin
        #(TIMEOUT_CYCLES * 2);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    // Test sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_identity();
        test_radial();
        test_tangential();
        test_saturation();
        test_ignored_address();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (NUM_STAGES + 8) @(posedge i_clk);
        $display("covered %0d points, %0d results (%0d clipped), %0d coefficient sets",
                 points_sent, results_seen, sat_seen, coef_sets);
        $display("including identity, saturation, unused register writes and hold-off");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ldp_pkg.sv
rtl/core/ldp_datapath.sv
rtl/core/lens_distortion_point_unit.sv
rtl/core/ldp_checker.sv
tb/tb_top.sv
